[rtl/tilt_angle_gyro_bias_kalman_defines.svh]
// assertion macros for the tilt angle kalman filter
// used by the checker module only
`ifndef TILT_ANGLE_GYRO_BIAS_KALMAN_DEFINES_SVH
`define TILT_ANGLE_GYRO_BIAS_KALMAN_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TAK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
// property that holds also during reset
`define TAK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

[rtl/tak_pkg.sv]
// shared types, constants and helpers for the tilt angle kalman filter
// no dependencies
package tak_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int RegW     = 16;
  localparam int AddrW    = 4;

  localparam logic [AddrW-1:0] AddrAngleNoise   = 4'h0;
  localparam logic [AddrW-1:0] AddrBiasNoise    = 4'h4;
  localparam logic [AddrW-1:0] AddrMeasureNoise = 4'h8;

  localparam logic [15:0] AngleNoiseRst   = 16'd66;
  localparam logic [15:0] BiasNoiseRst    = 16'd197;
  localparam logic [15:0] MeasureNoiseRst = 16'd1966;

  typedef logic signed [DataW-1:0] fix_t;

  // saturate a wide signed value to 32 bits
  function automatic fix_t sat32(input logic signed [65:0] v);
    fix_t r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

  // unsigned q0.16 to the internal fixed point
  function automatic fix_t from_q016(input logic [RegW-1:0] x);
    logic [DataW+RegW-1:0] w;
    w = {{DataW{1'b0}}, x};
    if (FracBits >= RegW) w = w << (FracBits - RegW);
    else w = w >> (RegW - FracBits);
    return fix_t'(w[DataW-1:0]);
  endfunction

endpackage

[rtl/tilt_angle_gyro_bias_kalman.sv]
// Two-state tilt angle kalman filter: angle plus gyro bias, 2x2 covariance.
// One item is accepted when s_axis_tready is high. A sequencer then drives one
// shared 32x32 multiplier (eleven products, each a multiply state then an
// accumulate state) and a restoring divider that gives one quotient bit per cycle
// (per gain: load, 49 quotient bits, write-back; two gains). The block takes no
// new item until the result has been taken.
// Depends on tak_pkg.
module tilt_angle_gyro_bias_kalman (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // measured_angle [31:0], gyro_rate [63:32], time_step [79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered_angle [31:0], bias_estimate [63:32]
  output logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [tak_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAcc  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  localparam int NSteps = 22;
  localparam int DivW   = 49;
  localparam int DivEnd = DivW + 1;

  logic [2:0] st_q, st_d;
  logic [4:0] step_q, step_d;
  logic [5:0] dcnt_q, dcnt_d;

  logic [15:0] qa_q, qb_q, rm_q;
  tak_pkg::fix_t ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
  tak_pkg::fix_t z_q, w_q, dt_q, t_q, s_q, k0_q, k1_q, inn_q, p00_q, p01_q;
  logic out_v_q;
  logic [63:0] out_q;

  // divider state: unsigned magnitudes
  logic [DivW-1:0] dn_q, quo_q;
  logic [31:0] rem_q;
  logic [31:0] dd_q;
  logic dneg_q;

  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= tak_pkg::AngleNoiseRst;
      qb_q <= tak_pkg::BiasNoiseRst;
      rm_q <= tak_pkg::MeasureNoiseRst;
    end else if (wr) begin
      case (paddr)
        tak_pkg::AddrAngleNoise:   qa_q <= pwdata[15:0];
        tak_pkg::AddrBiasNoise:    qb_q <= pwdata[15:0];
        tak_pkg::AddrMeasureNoise: rm_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      tak_pkg::AddrAngleNoise:   prdata = {16'd0, qa_q};
      tak_pkg::AddrBiasNoise:    prdata = {16'd0, qb_q};
      tak_pkg::AddrMeasureNoise: prdata = {16'd0, rm_q};
      default:                   prdata = '0;
    endcase
  end

  // operand selection for the shared multiplier, per step
  tak_pkg::fix_t ma, mb;
  always_comb begin
    ma = dt_q;
    mb = '0;
    case (step_q)
      5'd0:  mb = tak_pkg::sat32(66'(w_q) - 66'(bias_q));
      5'd1:  mb = pbb_q;
      5'd2:  mb = t_q;
      5'd3:  mb = pbb_q;
      5'd4:  begin ma = tak_pkg::from_q016(qb_q); mb = dt_q; end
      5'd5:  begin ma = k0_q; mb = inn_q; end
      5'd6:  begin ma = k1_q; mb = inn_q; end
      5'd7:  begin ma = k0_q; mb = p00_q; end
      5'd8:  begin ma = k0_q; mb = p01_q; end
      5'd9:  begin ma = k1_q; mb = p00_q; end
      5'd10: begin ma = k1_q; mb = p01_q; end
      default: ;
    endcase
  end

  logic signed [63:0] prod_q;
  tak_pkg::fix_t mres;
  logic signed [65:0] rnd;
  always_comb begin
    rnd  = 66'(prod_q) + (66'sd1 <<< (tak_pkg::FracBits - 1));
    mres = tak_pkg::sat32(rnd >>> tak_pkg::FracBits);
  end

  logic [32:0] rtry;
  logic [31:0] nabs;
  always_comb begin
    rtry = {rem_q, dn_q[DivW-1]} - {1'b0, dd_q};
    nabs = p00_q[31] ? 32'(-p00_q) : p00_q;
  end

  tak_pkg::fix_t qsat;
  always_comb begin
    if (dneg_q) qsat = tak_pkg::sat32(-66'(quo_q));
    else qsat = tak_pkg::sat32(66'(quo_q));
  end

  logic in_acc;
  assign s_axis_tready = (st_q == StIdle) && !out_v_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  always_comb begin
    st_d = st_q;
    step_d = step_q;
    dcnt_d = dcnt_q;
    case (st_q)
      StIdle: if (in_acc) begin st_d = StMul; step_d = '0; end
      StMul:  st_d = StAcc;
      StAcc: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd4 || step_q == 5'd11) begin
          st_d = StDiv; dcnt_d = '0;
        end else if (step_q == 5'd10) st_d = StOut;
        else st_d = StMul;
      end
      StDiv: begin
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'(DivEnd)) st_d = (step_q == 5'd12) ? StMul : StDiv;
        if (dcnt_q == 6'(DivEnd) && step_q == 5'd5) begin
          st_d = StDiv; step_d = 5'd12; dcnt_d = '0;
        end
        if (dcnt_q == 6'(DivEnd) && step_q == 5'd12) step_d = 5'd5;
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; step_q <= '0; dcnt_q <= '0; out_v_q <= 1'b0;
      ang_q <= '0; bias_q <= '0; paa_q <= '0; pab_q <= '0; pba_q <= '0; pbb_q <= '0;
    end else begin
      st_q <= st_d; step_q <= step_d; dcnt_q <= dcnt_d;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      if (st_q == StOut) begin
        out_v_q <= 1'b1;
        out_q <= {bias_q, ang_q};
      end
      if (in_acc) begin
        z_q <= s_axis_tdata[31:0];
        w_q <= s_axis_tdata[63:32];
        dt_q <= tak_pkg::from_q016(s_axis_tdata[79:64]);
      end
      if (st_q == StMul) prod_q <= 64'(ma) * 64'(mb);
      if (st_q == StAcc) begin
        case (step_q)
          5'd0: ang_q <= tak_pkg::sat32(66'(ang_q) + 66'(mres));
          5'd1: begin
            t_q <= tak_pkg::sat32(66'(tak_pkg::sat32(66'(tak_pkg::sat32(
                   66'(mres) - 66'(pab_q))) - 66'(pba_q))) + 66'(tak_pkg::from_q016(qa_q)));
          end
          5'd2: paa_q <= tak_pkg::sat32(66'(paa_q) + 66'(mres));
          5'd3: begin
            pab_q <= tak_pkg::sat32(66'(pab_q) - 66'(mres));
            pba_q <= tak_pkg::sat32(66'(pba_q) - 66'(mres));
          end
          5'd4: begin
            pbb_q <= tak_pkg::sat32(66'(pbb_q) + 66'(mres));
            s_q <= tak_pkg::sat32(66'(paa_q) + 66'(tak_pkg::from_q016(rm_q)));
            p00_q <= paa_q;
            p01_q <= pab_q;
            inn_q <= tak_pkg::sat32(66'(z_q) - 66'(ang_q));
          end
          5'd5: ang_q <= tak_pkg::sat32(66'(ang_q) + 66'(mres));
          5'd6: bias_q <= tak_pkg::sat32(66'(bias_q) + 66'(mres));
          5'd7: paa_q <= tak_pkg::sat32(66'(paa_q) - 66'(mres));
          5'd8: pab_q <= tak_pkg::sat32(66'(pab_q) - 66'(mres));
          5'd9: pba_q <= tak_pkg::sat32(66'(pba_q) - 66'(mres));
          5'd10: pbb_q <= tak_pkg::sat32(66'(pbb_q) - 66'(mres));
          default: ;
        endcase
      end
      if (st_q == StDiv) begin
        if (dcnt_q == '0) begin
          // load: numerator is p00 for k0, pba for k1
          if (step_q == 5'd12) begin
            dn_q <= {(pba_q[31] ? 32'(-pba_q) : pba_q), 17'd0} >> (17 - tak_pkg::FracBits);
            dneg_q <= pba_q[31] ^ s_q[31];
          end else begin
            dn_q <= {nabs, 17'd0} >> (17 - tak_pkg::FracBits);
            dneg_q <= p00_q[31] ^ s_q[31];
          end
          dd_q <= s_q[31] ? 32'(-s_q) : s_q;
          rem_q <= '0;
          quo_q <= '0;
        end else if (dcnt_q <= 6'(DivW)) begin
          dn_q <= dn_q << 1;
          if (!rtry[32]) begin
            rem_q <= rtry[31:0]; quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[30:0], dn_q[DivW-1]}; quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
        end
        if (dcnt_q == 6'(DivEnd)) begin
          if (step_q == 5'd5) k0_q <= (s_q == '0) ? '0 : qsat;
          else k1_q <= (s_q == '0) ? '0 : qsat;
        end
      end
    end
  end

endmodule

[rtl/tak_checker.sv]
// port-level checker for the tilt angle kalman filter, bound to the top level
// depends on tilt_angle_gyro_bias_kalman_defines.svh
`include "tilt_angle_gyro_bias_kalman_defines.svh"
module tak_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        pready
);
  `TAK_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `TAK_ASSERT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
  `TAK_ASSERT(a_no_in_with_out, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
  `TAK_ASSERT_ALWAYS(a_pready, clk_i, pready)
endmodule

bind tilt_angle_gyro_bias_kalman tak_checker u_tak_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

[dv/tilt_angle_gyro_bias_kalman_tb.sv]
// self-checking testbench for the tilt angle kalman filter (angle plus gyro bias)
// predicts each filtered angle and bias in q16.16 and compares them on the result stream
// depends on tak_pkg and tilt_angle_gyro_bias_kalman
module tilt_angle_gyro_bias_kalman_tb;

  localparam int MaxCycles = 3000000;

  typedef struct packed {
    logic signed [31:0] bias;
    logic signed [31:0] angle;
  } kal_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [tak_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kal_out_t    expected_q[$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          stall_cnt = 0;
  bit          quiet_mode = 1'b0;

  // predictor state
  logic [15:0] q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

  always #6 clk_i = ~clk_i;

  tilt_angle_gyro_bias_kalman DUT (.*);

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
    return clamp32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
    return clamp32(66'(a) - 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (tak_pkg::FracBits - 1));
    return clamp32(p >>> tak_pkg::FracBits);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] num, den);
    logic signed [65:0] n;
    if (den == 0) return '0;
    n = 66'(num) <<< tak_pkg::FracBits;
    return clamp32(n / 66'(den));
  endfunction

  function automatic logic signed [31:0] q016_to_fx(input logic [15:0] x);
    return 32'(x) << (tak_pkg::FracBits - 16);
  endfunction

  function automatic kal_out_t kalman_update(input logic signed [31:0] z, w,
                                             input logic [15:0] dt_raw);
    logic signed [31:0] dt, rate, t, s, k0, k1, innov, p00, p01;
    kal_out_t r;
    dt = q016_to_fx(dt_raw);
    rate = fx_sub(w, est_bias);
    est_angle = fx_add(est_angle, fx_mul(dt, rate));
    t = fx_mul(dt, p_bb);
    t = fx_sub(t, p_ab);
    t = fx_sub(t, p_ba);
    t = fx_add(t, q016_to_fx(q_angle));
    p_aa = fx_add(p_aa, fx_mul(dt, t));
    p_ab = fx_sub(p_ab, fx_mul(dt, p_bb));
    p_ba = fx_sub(p_ba, fx_mul(dt, p_bb));
    p_bb = fx_add(p_bb, fx_mul(q016_to_fx(q_bias), dt));
    s = fx_add(p_aa, q016_to_fx(r_meas));
    k0 = fx_div(p_aa, s);
    k1 = fx_div(p_ba, s);
    innov = fx_sub(z, est_angle);
    est_angle = fx_add(est_angle, fx_mul(k0, innov));
    est_bias = fx_add(est_bias, fx_mul(k1, innov));
    p00 = p_aa;
    p01 = p_ab;
    p_aa = fx_sub(p_aa, fx_mul(k0, p00));
    p_ab = fx_sub(p_ab, fx_mul(k0, p01));
    p_ba = fx_sub(p_ba, fx_mul(k1, p00));
    p_bb = fx_sub(p_bb, fx_mul(k1, p01));
    r.angle = est_angle;
    r.bias = est_bias;
    return r;
  endfunction

  task automatic idle_burst();
    if (!quiet_mode && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [31:0] z, w, input logic [15:0] dt);
    idle_burst();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dt, w, z};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(kalman_update(z, w, dt));
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [tak_pkg::AddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (addr)
      tak_pkg::AddrAngleNoise:   q_angle = data[15:0];
      tak_pkg::AddrBiasNoise:    q_bias = data[15:0];
      tak_pkg::AddrMeasureNoise: r_meas = data[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_noise(input logic [15:0] qa, qb, rm);
    drain_results();
    apb_write(tak_pkg::AddrAngleNoise, {16'($urandom_range(0, 65535)), qa});
    apb_write(tak_pkg::AddrBiasNoise, {16'($urandom_range(0, 65535)), qb});
    apb_write(tak_pkg::AddrMeasureNoise, {16'($urandom_range(0, 65535)), rm});
  endtask

  task automatic test_extremes();
    logic signed [31:0] vals [6] = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh00010000};
    foreach (vals[i]) send_sample(vals[i], vals[5 - i], 16'hffff);
    send_sample(32'sh7fffffff, 32'sh7fffffff, 16'h0000);
    send_sample(32'sh80000000, 32'sh80000000, 16'h8000);
    send_sample(32'sh55555555, 32'shaaaaaaaa, 16'h5555);
    send_sample(32'shaaaaaaaa, 32'sh55555555, 16'haaaa);
  endtask

  task automatic test_zero_divisor();
    // zero measurement noise with a clean covariance gives a zero innovation variance
    set_noise(16'h0000, 16'h0000, 16'h0000);
    send_sample(32'sh00050000, 32'sh00010000, 16'h0000);
    send_sample(-32'sh00030000, 32'sh00020000, 16'h0000);
    send_sample(32'sh00010000, -32'sh00010000, 16'h0147);
    send_sample(32'sh00020000, 32'sh00000000, 16'h0147);
  endtask

  task automatic test_noise_extremes();
    set_noise(16'hffff, 16'hffff, 16'hffff);
    repeat (4) send_sample($urandom, $urandom, 16'($urandom_range(0, 65535)));
    set_noise(16'h0000, 16'h0000, 16'h0001);
    repeat (4) send_sample($urandom, $urandom, 16'($urandom_range(0, 65535)));
  endtask

  task automatic random_run(input int n, input int realistic);
    logic signed [31:0] z, w;
    logic [15:0] dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < realistic) begin
        z = $signed($urandom_range(0, 180 << 16)) - (90 <<< 16);
        w = $signed($urandom_range(0, 500 << 16)) - (250 <<< 16);
        dt = 16'($urandom_range(30, 1400));
      end else begin
        z = $urandom;
        w = $urandom;
        dt = 16'($urandom_range(0, 65535));
      end
      send_sample(z, w, dt);
    end
  endtask

  task automatic test_random();
    set_noise(16'd66, 16'd197, 16'd1966);
    random_run(500, 85);
    // hold the sender until the filter is empty
    drain_results();
    random_run(100, 85);
    set_noise(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(1, 65535)));
    random_run(400, 70);
    set_noise(16'($urandom_range(0, 300)), 16'($urandom_range(0, 600)),
              16'($urandom_range(100, 8000)));
    random_run(400, 90);
    quiet_mode = 1'b1;
    random_run(400, 80);
  endtask

  always @(posedge clk_i) begin
    if (quiet_mode) begin
      m_axis_tready <= 1'b1;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      if (stall_cnt == 1) m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_cnt <= $urandom_range(1, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    kal_out_t exp_r;
    kal_out_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.angle !== exp_r.angle) begin
          $error("filtered_angle expected %0d actual %0d", exp_r.angle, got.angle);
          fail_cnt++;
        end
        if (got.bias !== exp_r.bias) begin
          $error("bias_estimate expected %0d actual %0d", exp_r.bias, got.bias);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    fork
      begin
        wait (cycle_cnt >= MaxCycles);
        $display("*** FAILED ***");
        $finish;
      end
    join_none
  end

  initial begin
    q_angle = 16'd66;
    q_bias = 16'd197;
    r_meas = 16'd1966;
    est_angle = '0;
    est_bias = '0;
    p_aa = '0;
    p_ab = '0;
    p_ba = '0;
    p_bb = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_zero_divisor();
    test_noise_extremes();
    test_random();
    drain_results();
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
